### hw/rtl/stream_find_and_replace_core_macros.svh
// Assertion helpers for the checker of this block.
// Every property is clocked on clk_i and disabled while rst_ni is low.
`ifndef STREAM_FIND_AND_REPLACE_CORE_MACROS_SVH
`define STREAM_FIND_AND_REPLACE_CORE_MACROS_SVH

// Same-cycle implication.
`define SFR_ASSERT_IMP(name, ante, cons) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("sfr assertion failed");

// Next-cycle implication.
`define SFR_ASSERT_NXT(name, ante, cons) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("sfr assertion failed");

`endif

### hw/rtl/sfr_pkg.sv
`timescale 1ns / 1ps

package sfr_pkg;

  localparam int unsigned WinDepth = 8;
  localparam int unsigned ByteW    = 8;
  localparam int unsigned LenW     = 4;
  localparam int unsigned CfgW     = 64;
  localparam int unsigned CfgIdxW  = 2;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_PATTERN   = 2'd0,
    CFG_MATCH_LEN = 2'd1,
    CFG_REPL_TEXT = 2'd2,
    CFG_REPL_LEN  = 2'd3
  } sfr_cfg_idx_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_POP,
    ST_REPL
  } sfr_state_e;

  // Per-cell control from the sequencer.
  typedef struct packed {
    logic shift;   // take the neighbour's byte
    logic tap;     // this cell is the tail: see the incoming byte
    logic in_use;  // cell lies inside the current pattern length
  } sfr_cell_ctl_t;

endpackage

### hw/rtl/sfr_ifs.sv
`timescale 1ns / 1ps

interface sfr_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] text_byte;
  logic       end_of_text;

  modport source (output valid, output text_byte, output end_of_text, input ready);
  modport sink (input valid, input text_byte, input end_of_text, output ready);
endinterface

interface sfr_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       byte_valid;
  logic       last_of_run;
  logic       text_done;

  modport source (
    output valid, output out_byte, output byte_valid, output last_of_run,
    output text_done, input ready
  );
  modport sink (
    input valid, input out_byte, input byte_valid, input last_of_run,
    input text_done, output ready
  );
endinterface

### hw/rtl/sfr_cell.sv
`timescale 1ns / 1ps

// One window slot: holds a byte, compares it with its pattern byte and
// hands it down the row on a shift.
module sfr_cell import sfr_pkg::*; (
  input  logic             clk_i,
  input  sfr_cell_ctl_t    ctl_i,
  input  logic [ByteW-1:0] in_byte_i,
  input  logic [ByteW-1:0] nbr_byte_i,
  input  logic [ByteW-1:0] pat_byte_i,
  input  logic             match_i,
  output logic [ByteW-1:0] eff_byte_o,
  output logic             match_o
);

  logic [ByteW-1:0] byte_q, byte_d;

  assign eff_byte_o = ctl_i.tap ? in_byte_i : byte_q;
  assign match_o    = match_i & (~ctl_i.in_use | (eff_byte_o == pat_byte_i));
  assign byte_d     = ctl_i.shift ? nbr_byte_i : eff_byte_o;

  always_ff @(posedge clk_i) begin
    byte_q <= byte_d;
  end

endmodule

### hw/rtl/stream_find_and_replace_core.sv
`timescale 1ns / 1ps

// Streaming find-and-replace-all over a byte stream.
// text_i carries one input word per handshake: a text byte and an end flag.
// text_o carries one result word per handshake: a byte, a flag telling
// whether the byte is data or a bare end marker, the last-of-run flag that
// closes the results of one input word, and the text-done flag that closes
// the whole text.
// The pending window is a row of cells, one per pattern byte. The incoming
// byte drops into the tail cell, every cell compares itself with its
// pattern byte and the match travels along the row combinationally.
// The first result of an input word is registered on text_o in the cycle
// after the word is taken. Throughput: one input word per cycle while each
// word causes at most one result and text_o is not stalled. A word that
// causes more results (replacement expansion, flush at end of text) sends
// them one by one through the single output register, with text_i.ready low until the last is sent.
// A full output register that is not taken simply holds; the next input
// word is still taken in the cycle the result leaves.
// Reset empties the window, drops any result in flight and returns the
// registers to pattern 0, length 1, replacement 0, length 0. There is no
// clearing pass: the first word can be sent in the cycle after reset.
// Configuration must be written through cfg_we_i/cfg_idx_i/cfg_data_i while idle; the block does not check.
module stream_find_and_replace_core import sfr_pkg::*; #(
  parameter int unsigned PATTERN_MAX = 8,
  parameter int unsigned REPLACE_MAX = 8
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [CfgIdxW-1:0] cfg_idx_i,
  input  logic [CfgW-1:0]    cfg_data_i,
  sfr_in_if.sink             text_i,
  sfr_out_if.source          text_o
);

  localparam int unsigned Cells    = (PATTERN_MAX < WinDepth) ? PATTERN_MAX : WinDepth;
  localparam int unsigned RepBytes = (REPLACE_MAX < WinDepth) ? REPLACE_MAX : WinDepth;
  localparam int unsigned RepIdxW  = (RepBytes > 1) ? $clog2(RepBytes) : 1;

  // Configuration: keep only the bytes that can ever be used.
  logic [Cells*ByteW-1:0]    pattern_q;
  logic [LenW-1:0]           mlen_q;
  logic [RepBytes*ByteW-1:0] rep_q;
  logic [LenW-1:0]           rlen_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pattern_q <= '0;
      mlen_q    <= LenW'(1);
      rep_q     <= '0;
      rlen_q    <= '0;
    end else if (cfg_we_i) begin
      case (sfr_cfg_idx_e'(cfg_idx_i))
        CFG_PATTERN:   pattern_q <= cfg_data_i[Cells*ByteW-1:0];
        CFG_MATCH_LEN: mlen_q    <= cfg_data_i[LenW-1:0];
        CFG_REPL_TEXT: rep_q     <= cfg_data_i[RepBytes*ByteW-1:0];
        CFG_REPL_LEN:  rlen_q    <= cfg_data_i[LenW-1:0];
        default: ;
      endcase
    end
  end

  // Saturate lengths: a zero pattern acts as one byte.
  logic [LenW-1:0] plen, rlen;

  always_comb begin
    if (mlen_q == '0) begin
      plen = LenW'(1);
    end else if (mlen_q > LenW'(Cells)) begin
      plen = LenW'(Cells);
    end else begin
      plen = mlen_q;
    end
    if (rlen_q > LenW'(RepBytes)) begin
      rlen = LenW'(RepBytes);
    end else begin
      rlen = rlen_q;
    end
  end

  // Control state.
  sfr_state_e         state_q, state_d;
  logic [LenW-1:0]    fill_q, fill_d;
  logic [LenW-1:0]    cnt_q, cnt_d;
  logic [RepIdxW-1:0] idx_q, idx_d;
  logic               run_last_q, run_last_d;

  // Output register.
  logic             out_valid_q;
  logic [ByteW-1:0] out_byte_q;
  logic             byte_valid_q, last_of_run_q, text_done_q;

  logic adv, in_ready, acc, last, shift;
  assign adv      = ~out_valid_q | text_o.ready;
  assign in_ready = (state_q == ST_IDLE) & adv;
  assign acc      = text_i.valid & in_ready;
  assign last     = text_i.end_of_text;

  // Row of cells.
  logic [ByteW-1:0] eff [Cells];
  logic [Cells:0]   chain;
  sfr_cell_ctl_t    ctl [Cells];

  assign chain[0] = 1'b1;

  for (genvar k = 0; k < Cells; k++) begin : g_cell
    logic [ByteW-1:0] nbr;

    if (k == Cells - 1) begin : g_end
      assign nbr = '0;
    end else begin : g_mid
      assign nbr = eff[k+1];
    end

    assign ctl[k].shift  = shift;
    assign ctl[k].tap    = acc & (fill_q == LenW'(k));
    assign ctl[k].in_use = LenW'(k) < plen;

    sfr_cell u_cell (
      .clk_i      (clk_i),
      .ctl_i      (ctl[k]),
      .in_byte_i  (text_i.text_byte),
      .nbr_byte_i (nbr),
      .pat_byte_i (pattern_q[k*ByteW +: ByteW]),
      .match_i    (chain[k]),
      .eff_byte_o (eff[k]),
      .match_o    (chain[k+1])
    );
  end

  // Decide what the accepted word does to the window.
  logic [LenW-1:0] fill_app, pop_cnt;
  logic            full, over, hit;

  assign fill_app = fill_q + LenW'(1);
  assign full     = fill_app == plen;
  assign over     = fill_app > plen;
  assign hit      = chain[Cells] & full;

  always_comb begin
    if (last) begin
      pop_cnt = fill_app;
    end else if (over) begin
      pop_cnt = fill_app - plen + LenW'(1);
    end else if (full & ~hit) begin
      pop_cnt = LenW'(1);
    end else begin
      pop_cnt = '0;
    end
  end

  // Sequencer: first result goes out with the accept, the rest follow.
  logic             emit, e_valid, e_lor, e_done;
  logic [ByteW-1:0] e_byte;

  always_comb begin
    state_d    = state_q;
    fill_d     = fill_q;
    cnt_d      = cnt_q;
    idx_d      = idx_q;
    run_last_d = run_last_q;
    shift      = 1'b0;
    emit       = 1'b0;
    e_byte     = '0;
    e_valid    = 1'b1;
    e_lor      = 1'b0;
    e_done     = 1'b0;
    case (state_q)
      ST_IDLE: begin
        if (acc) begin
          run_last_d = last;
          if (hit) begin
            fill_d = '0;
            if (rlen != '0) begin
              emit   = 1'b1;
              e_byte = rep_q[ByteW-1:0];
              e_lor  = rlen == LenW'(1);
              e_done = (rlen == LenW'(1)) & last;
              if (rlen > LenW'(1)) begin
                state_d = ST_REPL;
                cnt_d   = rlen - LenW'(1);
                idx_d   = RepIdxW'(1);
              end
            end else if (last) begin
              // match deleted the tail of the text: send a bare end marker
              emit    = 1'b1;
              e_valid = 1'b0;
              e_lor   = 1'b1;
              e_done  = 1'b1;
            end
          end else if (pop_cnt != '0) begin
            shift  = 1'b1;
            emit   = 1'b1;
            e_byte = eff[0];
            fill_d = fill_app - LenW'(1);
            e_lor  = pop_cnt == LenW'(1);
            e_done = (pop_cnt == LenW'(1)) & last;
            if (pop_cnt > LenW'(1)) begin
              state_d = ST_POP;
              cnt_d   = pop_cnt - LenW'(1);
            end
          end else begin
            fill_d = fill_app;
          end
        end
      end
      ST_POP: begin
        if (adv) begin
          shift  = 1'b1;
          emit   = 1'b1;
          e_byte = eff[0];
          fill_d = fill_q - LenW'(1);
          cnt_d  = cnt_q - LenW'(1);
          if (cnt_q == LenW'(1)) begin
            e_lor   = 1'b1;
            e_done  = run_last_q;
            state_d = ST_IDLE;
          end
        end
      end
      ST_REPL: begin
        if (adv) begin
          emit   = 1'b1;
          e_byte = rep_q[idx_q*ByteW +: ByteW];
          idx_d  = idx_q + RepIdxW'(1);
          cnt_d  = cnt_q - LenW'(1);
          if (cnt_q == LenW'(1)) begin
            e_lor   = 1'b1;
            e_done  = run_last_q;
            state_d = ST_IDLE;
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      fill_q     <= '0;
      cnt_q      <= '0;
      idx_q      <= '0;
      run_last_q <= 1'b0;
    end else begin
      state_q    <= state_d;
      fill_q     <= fill_d;
      cnt_q      <= cnt_d;
      idx_q      <= idx_d;
      run_last_q <= run_last_d;
    end
  end

  // Advance the output register when empty or taken; otherwise hold.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (adv) begin
      out_valid_q <= emit;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv & emit) begin
      out_byte_q    <= e_byte;
      byte_valid_q  <= e_valid;
      last_of_run_q <= e_lor;
      text_done_q   <= e_done;
    end
  end

  assign text_i.ready       = in_ready;
  assign text_o.valid       = out_valid_q;
  assign text_o.out_byte    = out_byte_q;
  assign text_o.byte_valid  = byte_valid_q;
  assign text_o.last_of_run = last_of_run_q;
  assign text_o.text_done   = text_done_q;

endmodule

### hw/rtl/sfr_checker.sv
`timescale 1ns / 1ps
`include "stream_find_and_replace_core_macros.svh"

module sfr_checker import sfr_pkg::*; (
  input logic             clk_i,
  input logic             rst_ni,
  input logic             in_ready_i,
  input logic             out_valid_i,
  input logic             out_ready_i,
  input logic [ByteW-1:0] out_byte_i,
  input logic             byte_valid_i,
  input logic             last_of_run_i,
  input logic             text_done_i
);

  // hold a stalled word
  `SFR_ASSERT_NXT(a_out_hold, out_valid_i && !out_ready_i, out_valid_i && $stable(out_byte_i))
  // end of text always closes a run
  `SFR_ASSERT_IMP(a_done_closes_run, out_valid_i && text_done_i, last_of_run_i)
  // a bare marker only ends a text and carries a zero byte
  `SFR_ASSERT_IMP(a_bare_marker, out_valid_i && !byte_valid_i, text_done_i && out_byte_i == '0)
  // no new input while a run is still being delivered
  `SFR_ASSERT_IMP(a_run_blocks_input, out_valid_i && !last_of_run_i, !in_ready_i)

endmodule

bind stream_find_and_replace_core sfr_checker u_sfr_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .in_ready_i    (text_i.ready),
  .out_valid_i   (text_o.valid),
  .out_ready_i   (text_o.ready),
  .out_byte_i    (text_o.out_byte),
  .byte_valid_i  (text_o.byte_valid),
  .last_of_run_i (text_o.last_of_run),
  .text_done_i   (text_o.text_done)
);
